### hdl/wcs_pkg.sv
package wcs_pkg;

    // Field widths shared by the ports and the datapath.
    localparam int UNIT_W     = 8;
    localparam int TEMP_W     = 10;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_INLET_UNITS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PUMP_UNITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LATER_PUMP_UNITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTLET_UNITS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_TOTAL      = 3'd5;

    // Machine status codes.
    localparam logic [1:0] STATUS_IDLE      = 2'd0;
    localparam logic [1:0] STATUS_PREPARING = 2'd1;
    localparam logic [1:0] STATUS_WASHING   = 2'd2;
    localparam logic [1:0] STATUS_PAUSED    = 2'd3;

    // Error codes; a lower code wins when several are raised in one tick.
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_TEMP    = 3'd1;
    localparam logic [2:0] ERR_BAD_PUMP    = 3'd2;
    localparam logic [2:0] ERR_BAD_INLET   = 3'd3;
    localparam logic [2:0] ERR_TEMP_MISSED = 3'd4;
    localparam logic [2:0] ERR_BAD_DRAIN   = 3'd5;

    // One timer tick with all sensor levels and the start request write.
    typedef struct packed {
        logic              door_open;
        logic              door_closed;
        logic              valve_open_seen;
        logic              valve_closed_seen;
        logic              cooking_idle;
        logic              hold_all;
        logic [TEMP_W-1:0] oven_temp;
        logic              start_write;
        logic              start_value;
    } tick_t;

    // Phase, status and actuator levels reported after each tick.
    typedef struct packed {
        logic [3:0]         phase;
        logic [1:0]         machine_status;
        logic               pump_on;
        logic               heater_on;
        logic               motor_on;
        logic               steam_on;
        logic               drain_open_cmd;
        logic               drain_release;
        logic [2:0]         error_code;
        logic [COUNT_W-1:0] cycles_done;
    } result_t;

endpackage

### hdl/wash_cycle_sequencer.sv
// Oven wash-cycle sequencer.
//
// Each transfer on the tick channel (tick_valid/tick_ready, payload tick) is one
// timer tick carrying the door, drain valve and cooking-idle sensors, the global
// hold flag, the oven temperature and an optional write of the start request.
// For every tick exactly one transfer leaves on the result channel
// (result_valid/result_ready, payload result) with the phase, machine status,
// actuator levels, idle drain release pulse, error code and completed cycles.
// The registers are written through the cfg channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high and indexes above five are
// dropped. Registers are meant to be written while the block is idle.
//
// The result of a tick is valid in the cycle after its transfer. Throughput is
// one tick per cycle while results are taken, set by the single state update
// between the sequencer registers and the result register. When the receiver
// stalls, the result register holds and tick_ready drops until it is taken;
// a tick is still accepted in the same cycle that the waiting result leaves.
// Reset puts the sequencer in idle with all actuators off, the start request
// cleared, the registers at zero and no result pending.
module wash_cycle_sequencer #(
    parameter int TICKS_PER_UNIT   = 60,
    parameter int TOGGLE_TICKS     = 30,
    parameter int IDLE_DRAIN_TICKS = 60
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            tick_valid,
    output logic                            tick_ready,
    input  wcs_pkg::tick_t                  tick,
    output logic                            result_valid,
    input  logic                            result_ready,
    output wcs_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Timers hold the largest programmed duration; the idle drain reload is
    // cut to the timer width.
    localparam int UNIT_MAX = (2 ** wcs_pkg::UNIT_W) - 1;
    localparam int TIMER_W  = $clog2(UNIT_MAX * TICKS_PER_UNIT + 1);
    localparam int TOG_W    = $clog2(TOGGLE_TICKS + 1);
    localparam int TW       = wcs_pkg::TEMP_W;
    localparam int UW       = wcs_pkg::UNIT_W;
    localparam int CW       = wcs_pkg::COUNT_W;

    localparam logic [TIMER_W-1:0] TICK_UNIT_C  = TIMER_W'(TICKS_PER_UNIT);
    localparam logic [TIMER_W-1:0] IDLE_DRAIN_C = TIMER_W'(IDLE_DRAIN_TICKS);
    localparam logic [TOG_W-1:0]   TOGGLE_C     = TOG_W'(TOGGLE_TICKS);
    localparam logic [TW:0]        HYSTERESIS_C = (TW + 1)'(5);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_CONFIG = 4'd1,
        PH_INLET  = 4'd2,
        PH_TOGGLE = 4'd3,
        PH_WASH   = 4'd4,
        PH_DRAIN  = 4'd5,
        PH_RELOAD = 4'd6,
        PH_DONE   = 4'd7,
        PH_PAUSED = 4'd8
    } phase_t;

    // Actuator level bits.
    localparam logic [4:0] ACT_PUMP   = 5'b00001;
    localparam logic [4:0] ACT_HEATER = 5'b00010;
    localparam logic [4:0] ACT_MOTOR  = 5'b00100;
    localparam logic [4:0] ACT_STEAM  = 5'b01000;
    localparam logic [4:0] ACT_DRAIN  = 5'b10000;
    localparam logic [4:0] ACT_NONE   = 5'b00000;

    // A lower error code wins when several are raised in one tick.
    function automatic logic [2:0] keep_lowest(input logic [2:0] cur, input logic [2:0] code);
        logic [2:0] res;
        res = cur;
        if (cur == wcs_pkg::ERR_NONE || code < cur) begin
            res = code;
        end
        return res;
    endfunction

    // Configuration registers.
    logic [UW-1:0] inlet_units_reg;
    logic [UW-1:0] first_units_reg;
    logic [UW-1:0] later_units_reg;
    logic [UW-1:0] outlet_units_reg;
    logic [TW-1:0] target_temp_reg;
    logic [CW-1:0] cycle_total_reg;

    // Sequencer state.
    phase_t             cur_phase_reg, cur_phase_next;
    phase_t             prior_phase_reg, prior_phase_next;
    logic [TIMER_W-1:0] wash_timer_reg, wash_timer_next;
    logic [TIMER_W-1:0] inlet_timer_reg, inlet_timer_next;
    logic [TIMER_W-1:0] drain_timer_reg, drain_timer_next;
    logic [TOG_W-1:0]   toggle_on_reg, toggle_on_next;
    logic [TOG_W-1:0]   toggle_off_reg, toggle_off_next;
    logic [CW-1:0]      cycle_count_reg, cycle_count_next;
    logic               temp_reached_reg, temp_reached_next;
    logic               heat_latched_reg, heat_latched_next;
    logic               start_request_reg, start_request_next;
    logic [4:0]         act_reg, act_next;
    logic [TW-1:0]      latched_target_reg, latched_target_next;
    logic [1:0]         status_reg, status_next;

    logic             result_valid_reg;
    wcs_pkg::result_t result_reg, result_next;
    logic             release_pulse;
    logic [2:0]       err_code;
    logic             tick_accept;

    assign cfg_ready    = 1'b1;
    assign tick_ready   = !result_valid_reg || result_ready;
    assign tick_accept  = tick_valid && tick_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // One tick of the sequencer, evaluated on the current state.
    always_comb
    begin
        cur_phase_next      = cur_phase_reg;
        prior_phase_next    = prior_phase_reg;
        wash_timer_next     = wash_timer_reg;
        inlet_timer_next    = inlet_timer_reg;
        drain_timer_next    = drain_timer_reg;
        toggle_on_next      = toggle_on_reg;
        toggle_off_next     = toggle_off_reg;
        cycle_count_next    = cycle_count_reg;
        temp_reached_next   = temp_reached_reg;
        heat_latched_next   = heat_latched_reg;
        start_request_next  = start_request_reg;
        act_next            = act_reg;
        latched_target_next = latched_target_reg;
        status_next         = status_reg;
        release_pulse       = 1'b0;
        err_code            = wcs_pkg::ERR_NONE;

        if (tick.start_write) begin
            start_request_next = tick.start_value;
        end

        // Clearing the start request aborts a run through the done phase.
        if (cur_phase_next != PH_IDLE && !start_request_next) begin
            cur_phase_next = PH_DONE;
        end

        if (!tick.hold_all) begin
            unique case (cur_phase_next)
                PH_IDLE:
                begin
                    if (start_request_next) begin
                        cur_phase_next = PH_CONFIG;
                    end
                    if (tick.cooking_idle) begin
                        if (drain_timer_reg != '0) begin
                            drain_timer_next = drain_timer_reg - TIMER_W'(1);
                        end else if (tick.valve_open_seen) begin
                            release_pulse    = 1'b1;
                            drain_timer_next = IDLE_DRAIN_C;
                        end
                    end
                end
                PH_CONFIG:
                begin
                    prior_phase_next = PH_CONFIG;
                    status_next      = wcs_pkg::STATUS_PREPARING;
                    if (tick.door_open) begin
                        cur_phase_next = PH_PAUSED;
                    end
                    act_next = act_next & ~(ACT_STEAM | ACT_MOTOR);
                    // A closed door wins over an open one read in the same tick.
                    if (tick.door_closed) begin
                        latched_target_next = target_temp_reg;
                        if (target_temp_reg == '0) begin
                            err_code = keep_lowest(err_code, wcs_pkg::ERR_BAD_TEMP);
                        end
                        wash_timer_next = TIMER_W'(first_units_reg) * TICK_UNIT_C;
                        if (first_units_reg == '0) begin
                            err_code = keep_lowest(err_code, wcs_pkg::ERR_BAD_PUMP);
                        end
                        inlet_timer_next = TIMER_W'(inlet_units_reg) * TICK_UNIT_C;
                        if (inlet_units_reg == '0) begin
                            err_code = keep_lowest(err_code, wcs_pkg::ERR_BAD_INLET);
                        end
                        act_next       = (act_next & ~ACT_DRAIN) | ACT_STEAM;
                        cur_phase_next = PH_INLET;
                    end
                end
                PH_INLET:
                begin
                    prior_phase_next = PH_INLET;
                    status_next      = wcs_pkg::STATUS_WASHING;
                    if (tick.door_open) begin
                        cur_phase_next = PH_PAUSED;
                    end
                    if (inlet_timer_reg != '0) begin
                        inlet_timer_next = inlet_timer_reg - TIMER_W'(1);
                    end else begin
                        cur_phase_next = PH_TOGGLE;
                        act_next       = (act_next & ~ACT_STEAM) | ACT_HEATER;
                    end
                end
                PH_TOGGLE:
                begin
                    if (toggle_on_reg != '0) begin
                        if (toggle_on_reg == TOGGLE_C) begin
                            act_next = act_next | ACT_PUMP;
                        end
                        toggle_on_next = toggle_on_reg - TOG_W'(1);
                    end
                    if (toggle_on_next == '0) begin
                        if (toggle_off_reg != '0) begin
                            if (toggle_off_reg == TOGGLE_C) begin
                                act_next = act_next & ~ACT_PUMP;
                            end
                            toggle_off_next = toggle_off_reg - TOG_W'(1);
                        end else begin
                            cur_phase_next  = PH_WASH;
                            toggle_on_next  = TOGGLE_C;
                            toggle_off_next = TOGGLE_C;
                            act_next        = act_next | ACT_PUMP;
                        end
                    end
                end
                PH_WASH:
                begin
                    status_next = wcs_pkg::STATUS_WASHING;
                    if (tick.door_open) begin
                        prior_phase_next = PH_WASH;
                        cur_phase_next   = PH_PAUSED;
                    end
                    // Heater and fan follow the temperature with a hysteresis band.
                    if (tick.oven_temp >= latched_target_reg) begin
                        act_next          = act_next & ~(ACT_HEATER | ACT_MOTOR);
                        temp_reached_next = 1'b1;
                        heat_latched_next = 1'b0;
                    end else if (({1'b0, tick.oven_temp} + HYSTERESIS_C)
                                 <= {1'b0, latched_target_reg}) begin
                        if (!heat_latched_reg) begin
                            act_next          = act_next | ACT_MOTOR | ACT_HEATER;
                            heat_latched_next = 1'b1;
                        end
                    end
                    if (cycle_count_reg < cycle_total_reg) begin
                        if (wash_timer_reg != '0) begin
                            wash_timer_next = wash_timer_reg - TIMER_W'(1);
                        end else begin
                            act_next = (act_next & ~(ACT_PUMP | ACT_HEATER | ACT_MOTOR))
                                       | ACT_DRAIN;
                            cur_phase_next = PH_DRAIN;
                            if (temp_reached_next) begin
                                temp_reached_next = 1'b0;
                            end else begin
                                err_code = keep_lowest(err_code, wcs_pkg::ERR_TEMP_MISSED);
                            end
                            drain_timer_next = TIMER_W'(outlet_units_reg) * TICK_UNIT_C;
                        end
                    end
                end
                PH_DRAIN:
                begin
                    status_next = wcs_pkg::STATUS_WASHING;
                    if (tick.door_open) begin
                        prior_phase_next = PH_DRAIN;
                        cur_phase_next   = PH_PAUSED;
                    end
                    if (tick.valve_open_seen) begin
                        if (drain_timer_reg != '0) begin
                            drain_timer_next = drain_timer_reg - TIMER_W'(1);
                        end else begin
                            act_next         = act_next & ~ACT_DRAIN;
                            cur_phase_next   = PH_RELOAD;
                            cycle_count_next = cycle_count_reg + CW'(1);
                        end
                    end
                end
                PH_RELOAD:
                begin
                    if (tick.door_open) begin
                        prior_phase_next = PH_RELOAD;
                        cur_phase_next   = PH_PAUSED;
                    end
                    if (tick.valve_closed_seen) begin
                        if (cycle_count_reg < cycle_total_reg) begin
                            wash_timer_next = TIMER_W'(later_units_reg) * TICK_UNIT_C;
                            if (later_units_reg == '0) begin
                                err_code = keep_lowest(err_code, wcs_pkg::ERR_BAD_PUMP);
                            end
                            inlet_timer_next = TIMER_W'(inlet_units_reg) * TICK_UNIT_C;
                            if (inlet_units_reg == '0) begin
                                err_code = keep_lowest(err_code, wcs_pkg::ERR_BAD_INLET);
                            end
                            drain_timer_next = TIMER_W'(outlet_units_reg) * TICK_UNIT_C;
                            if (outlet_units_reg == '0) begin
                                err_code = keep_lowest(err_code, wcs_pkg::ERR_BAD_DRAIN);
                            end
                            act_next = (act_next & ~(ACT_HEATER | ACT_DRAIN)) | ACT_STEAM;
                            cur_phase_next = PH_INLET;
                        end else begin
                            cur_phase_next = PH_DONE;
                        end
                    end
                end
                PH_DONE:
                begin
                    prior_phase_next   = PH_DONE;
                    drain_timer_next   = IDLE_DRAIN_C;
                    act_next           = ACT_DRAIN;
                    cycle_count_next   = '0;
                    cur_phase_next     = PH_IDLE;
                    heat_latched_next  = 1'b0;
                    start_request_next = 1'b0;
                    status_next        = wcs_pkg::STATUS_IDLE;
                end
                PH_PAUSED:
                begin
                    act_next    = ACT_NONE;
                    status_next = wcs_pkg::STATUS_PAUSED;
                    if (tick.door_closed) begin
                        priority case (prior_phase_reg)
                            PH_INLET:
                            begin
                                act_next       = ACT_STEAM;
                                cur_phase_next = PH_INLET;
                            end
                            PH_WASH:
                            begin
                                act_next       = ACT_MOTOR | ACT_HEATER | ACT_PUMP;
                                cur_phase_next = PH_WASH;
                            end
                            PH_DRAIN:
                            begin
                                act_next       = ACT_DRAIN;
                                cur_phase_next = PH_DRAIN;
                            end
                            PH_CONFIG:
                            begin
                                cur_phase_next = PH_IDLE;
                            end
                            PH_RELOAD:
                            begin
                                cur_phase_next = PH_RELOAD;
                            end
                            default:
                            begin
                                // An unknown prior phase stays paused until abort.
                                cur_phase_next = PH_PAUSED;
                            end
                        endcase
                    end
                end
                default:
                begin
                    cur_phase_next = cur_phase_reg;
                end
            endcase
        end

        result_next.phase          = cur_phase_next;
        result_next.machine_status = status_next;
        result_next.pump_on        = act_next[0];
        result_next.heater_on      = act_next[1];
        result_next.motor_on       = act_next[2];
        result_next.steam_on       = act_next[3];
        result_next.drain_open_cmd = act_next[4];
        result_next.drain_release  = release_pulse;
        result_next.error_code     = err_code;
        result_next.cycles_done    = cycle_count_next;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            inlet_units_reg  <= '0;
            first_units_reg  <= '0;
            later_units_reg  <= '0;
            outlet_units_reg <= '0;
            target_temp_reg  <= '0;
            cycle_total_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                wcs_pkg::REG_INLET_UNITS:      inlet_units_reg  <= cfg_data[UW-1:0];
                wcs_pkg::REG_FIRST_PUMP_UNITS: first_units_reg  <= cfg_data[UW-1:0];
                wcs_pkg::REG_LATER_PUMP_UNITS: later_units_reg  <= cfg_data[UW-1:0];
                wcs_pkg::REG_OUTLET_UNITS:     outlet_units_reg <= cfg_data[UW-1:0];
                wcs_pkg::REG_TARGET_TEMP:      target_temp_reg  <= cfg_data[TW-1:0];
                wcs_pkg::REG_CYCLE_TOTAL:      cycle_total_reg  <= cfg_data[CW-1:0];
                default:                       ;
            endcase
        end
    end

    // Sequencer state advances on every accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_phase_reg      <= PH_IDLE;
            prior_phase_reg    <= PH_IDLE;
            wash_timer_reg     <= '0;
            inlet_timer_reg    <= '0;
            drain_timer_reg    <= IDLE_DRAIN_C;
            toggle_on_reg      <= TOGGLE_C;
            toggle_off_reg     <= TOGGLE_C;
            cycle_count_reg    <= '0;
            temp_reached_reg   <= 1'b0;
            heat_latched_reg   <= 1'b0;
            start_request_reg  <= 1'b0;
            act_reg            <= ACT_NONE;
            latched_target_reg <= '0;
            status_reg         <= wcs_pkg::STATUS_IDLE;
            result_valid_reg   <= 1'b0;
        end else begin
            if (tick_accept) begin
                cur_phase_reg      <= cur_phase_next;
                prior_phase_reg    <= prior_phase_next;
                wash_timer_reg     <= wash_timer_next;
                inlet_timer_reg    <= inlet_timer_next;
                drain_timer_reg    <= drain_timer_next;
                toggle_on_reg      <= toggle_on_next;
                toggle_off_reg     <= toggle_off_next;
                cycle_count_reg    <= cycle_count_next;
                temp_reached_reg   <= temp_reached_next;
                heat_latched_reg   <= heat_latched_next;
                start_request_reg  <= start_request_next;
                act_reg            <= act_next;
                latched_target_reg <= latched_target_next;
                status_reg         <= status_next;
                result_valid_reg   <= 1'b1;
            end else if (result_ready) begin
                result_valid_reg   <= 1'b0;
            end
        end
    end

    // Result payload; it only loads together with a new transfer.
    always_ff @(posedge clk)
    begin
        if (tick_accept) begin
            result_reg <= result_next;
        end
    end

    // Every accepted tick leaves a result behind it.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> result_valid)
        else $error("accepted tick produced no result");

    // The tick side only stalls behind a result that is waiting.
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_ready |-> (result_valid && !result_ready))
        else $error("tick channel stalled without a pending result");

    // A done phase that is not held ends in idle with the cycle count cleared.
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_accept && cur_phase_reg == PH_DONE && !tick.hold_all)
        |=> (result.phase == PH_IDLE && result.cycles_done == '0))
        else $error("done phase did not return to idle");

    // The idle drain release can only fire from the idle phase.
    a_release_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_accept && cur_phase_reg != PH_IDLE) |=> !result.drain_release)
        else $error("drain release outside idle");

endmodule
